// ----- rtl/dsrb_pkg.sv -----
// Shared types and constants for the deduplicating sorted result buffer.
// It has no dependencies. The store, the sequencer and the top level import it.
package dsrb_pkg;

	localparam int ADDR_W = 6;   // enough for the largest store of 64 entries
	localparam int CNT_W  = 7;   // entry count, 0 to 64 inclusive

	typedef struct packed {
		logic [63:0]        offset;
		logic signed [63:0] ts;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic overflow;
	} emit_t;

endpackage

// ----- rtl/dsrb_store.sv -----
// Entry store: the offset and timestamp memories, with one write port and one read port.
// The read data is registered. It depends on dsrb_pkg.
module dsrb_store #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  dsrb_pkg::mem_req_t req,
	output dsrb_pkg::entry_t   rdata
);
	import dsrb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [63:0]        offset_mem [DEPTH];
	logic signed [63:0] time_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			offset_mem[req.waddr[AW-1:0]] <= req.wdata.offset;
			time_mem[req.waddr[AW-1:0]]   <= req.wdata.ts;
		end
		rdata.offset <= offset_mem[req.raddr[AW-1:0]];
		rdata.ts     <= time_mem[req.raddr[AW-1:0]];
	end

endmodule

// ----- rtl/dsrb_ctrl.sv -----
// Sequencer for the result buffer. It scans for duplicates, does the shifting
// insert that keeps the store in order and reads the store out for emission.
// It depends on dsrb_pkg and drives the dsrb_store port.
module dsrb_ctrl #(
	parameter int CAPACITY = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [63:0]                      record_offset,
	input  logic signed [63:0]               timestamp,
	input  logic                             end_of_set,
	input  logic [dsrb_pkg::CNT_W-1:0]       result_limit,
	input  dsrb_pkg::entry_t                 rdata,
	output dsrb_pkg::mem_req_t               mem_req,
	output dsrb_pkg::emit_t                  emit,
	output logic                             busy
);
	import dsrb_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_WRAP  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;
	logic [63:0]        off_q;
	logic signed [63:0] ts_q;
	logic               last_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   pos_q;
	logic               dup_q;
	logic               rd_s1;
	logic               sh_s1;
	logic [ADDR_W-1:0]  sh_addr_s1;
	logic               em_s1;
	logic               em_last_s1;

	logic             scan_issue, scan_done, hit, ge, full;
	logic             shift_issue, shift_done, emit_issue, emit_done;
	logic [CNT_W-1:0] n_emit, idx_dec;

	assign scan_issue  = (state_q == ST_SCAN) && (idx_q < cnt_q);
	assign scan_done   = (state_q == ST_SCAN) && !scan_issue && !rd_s1;
	assign hit         = rd_s1 && (rdata.offset == off_q);
	// Entries with an equal or larger timestamp stay in front of the new one.
	assign ge          = rd_s1 && !(rdata.ts < ts_q);
	assign full        = cnt_q >= CNT_W'(CAPACITY);
	assign shift_issue = (state_q == ST_SHIFT) && (idx_q > pos_q);
	assign shift_done  = (state_q == ST_SHIFT) && !shift_issue && !sh_s1;
	assign n_emit      = (result_limit != '0 && result_limit < cnt_q) ? result_limit : cnt_q;
	assign emit_issue  = (state_q == ST_EMIT) && (idx_q < n_emit);
	assign emit_done   = (state_q == ST_EMIT) && !emit_issue && !em_s1;
	assign idx_dec     = idx_q - CNT_W'(1);

	always_comb begin
		mem_req.raddr = (state_q == ST_SHIFT) ? idx_dec[ADDR_W-1:0] : idx_q[ADDR_W-1:0];
		mem_req.we    = sh_s1 || shift_done;
		mem_req.waddr = sh_s1 ? sh_addr_s1 : pos_q[ADDR_W-1:0];
		if (sh_s1) begin
			mem_req.wdata = rdata;
		end else begin
			mem_req.wdata.offset = off_q;
			mem_req.wdata.ts     = ts_q;
		end
	end

	assign emit.valid    = em_s1;
	assign emit.last     = em_last_s1;
	assign emit.overflow = ovf_q;
	assign busy          = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			rd_s1   <= 1'b0;
			sh_s1   <= 1'b0;
			em_s1   <= 1'b0;
		end else begin
			rd_s1 <= scan_issue;
			sh_s1 <= shift_issue;
			em_s1 <= emit_issue;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						if (dup_q) begin
							state_q <= ST_WRAP;
						end else if (full) begin
							ovf_q   <= 1'b1;
							state_q <= ST_WRAP;
						end else begin
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (shift_done) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (emit_done) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload and index registers: these need no reset.
	always_ff @(posedge clk) begin
		sh_addr_s1 <= idx_q[ADDR_W-1:0];
		em_last_s1 <= (idx_q == n_emit - CNT_W'(1));
		case (state_q)
			ST_IDLE: begin
				off_q  <= record_offset;
				ts_q   <= timestamp;
				last_q <= end_of_set;
				idx_q  <= '0;
				pos_q  <= '0;
				dup_q  <= 1'b0;
			end
			ST_SCAN: begin
				if (scan_issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (hit) begin
					dup_q <= 1'b1;
				end
				if (ge) begin
					pos_q <= pos_q + CNT_W'(1);
				end
				if (scan_done) begin
					idx_q <= cnt_q;
				end
			end
			ST_SHIFT: begin
				if (shift_issue) begin
					idx_q <= idx_dec;
				end
			end
			ST_WRAP: begin
				idx_q <= '0;
			end
			ST_EMIT: begin
				if (emit_issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			default: begin
				idx_q <= '0;
			end
		endcase
	end

endmodule

// ----- rtl/dedup_sorted_result_buffer.sv -----
// Top level of the deduplicating sorted result buffer.
// It instantiates dsrb_store and dsrb_ctrl and depends on dsrb_pkg.
//
// The block collects (record offset, timestamp) words. An item is taken when start is
// high and busy is low. Busy stays high while the item is processed. The item's offset is
// checked against every stored entry through the store's single read port, one entry a
// cycle. A new pair is then put in place by shifting the entries that have smaller
// timestamps down by one, again one entry a cycle. The store is therefore always ordered
// by timestamp, largest first, and entries with equal timestamps keep their arrival order.
// Here count is the number of entries held. A duplicate or a dropped pair skips the shift.
// A final wrap-up state then closes the item. The read port paces the scan and the shift.
// On the item marked end_of_set the block reads out min(count, result_limit) entries,
// or all of them when result_limit is zero, one a cycle. It then clears the store.
// Each result word is presented for exactly one cycle with result_valid high. The
// receiver cannot stall the output, so it must take every word as it comes.
// last_result marks the final word of a run, and overflowed is set on every word of a
// run in which a new pair was dropped because the store was full. An empty run gives no
// words. result_limit may be written through the cfg channel while the block is idle.
// That channel is always ready.
module dedup_sorted_result_buffer #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [63:0]        record_offset,
	input  logic signed [63:0] timestamp,
	input  logic               end_of_set,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data,
	output logic               result_valid,
	output logic [63:0]        out_offset,
	output logic signed [63:0] out_timestamp,
	output logic               last_result,
	output logic               overflowed
);
	import dsrb_pkg::*;

	mem_req_t         mem_req;
	entry_t           rdata;
	emit_t            emit;
	logic [CNT_W-1:0] limit_q;
	logic             valid_q;
	logic [63:0]        offset_q;
	logic signed [63:0] ts_q;
	logic               last_q;
	logic               ovf_q;

	// The only configuration register is the limit on the number of words emitted.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			valid_q <= emit.valid;
		end
	end

	// The output register holds each emitted word for its single strobe cycle.
	always_ff @(posedge clk) begin
		if (emit.valid) begin
			offset_q <= rdata.offset;
			ts_q     <= rdata.ts;
			last_q   <= emit.last;
			ovf_q    <= emit.overflow;
		end
	end

	assign result_valid  = valid_q;
	assign out_offset    = offset_q;
	assign out_timestamp = ts_q;
	assign last_result   = last_q;
	assign overflowed    = ovf_q;

	dsrb_store #(
		.DEPTH(CAPACITY)
	) u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	dsrb_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.record_offset (record_offset),
		.timestamp     (timestamp),
		.end_of_set    (end_of_set),
		.result_limit  (limit_q),
		.rdata         (rdata),
		.mem_req       (mem_req),
		.emit          (emit),
		.busy          (busy)
	);

	// A word is only emitted out of a busy period.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result word without a preceding busy cycle");

	// The store is never written while the block is idle.
	a_write_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> busy)
		else $error("store write while idle");

	// The final word of a run is never followed directly by another word.
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_result) |=> !result_valid)
		else $error("result word directly after the last word of a run");

	// An accepted item makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

endmodule

// ----- test/tb.sv -----
// Testbench for dedup_sorted_result_buffer: drives (offset, timestamp) pairs and checks the
// sorted, deduplicated and limited result words against a predictor of its own.
// Depends on dsrb_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
	import dsrb_pkg::*;

	localparam int CAPACITY      = 64;
	localparam int SETTLE_CYCLES = 200;   // worst item with a full store plus the clearing pass
	localparam logic signed [63:0] TS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] TS_MIN = 64'sh8000_0000_0000_0000;

	typedef struct {
		entry_t pair;
		logic   eos;
	} pair_item_t;

	typedef struct {
		entry_t pair;
		logic   last;
		logic   ovf;
	} result_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [63:0]        record_offset = '0;
	logic signed [63:0] timestamp = '0;
	logic               end_of_set = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [6:0]         cfg_data = '0;
	logic               result_valid;
	logic [63:0]        out_offset;
	logic signed [63:0] out_timestamp;
	logic               last_result;
	logic               overflowed;

	dedup_sorted_result_buffer #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.record_offset(record_offset),
		.timestamp    (timestamp),
		.end_of_set   (end_of_set),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.out_offset   (out_offset),
		.out_timestamp(out_timestamp),
		.last_result  (last_result),
		.overflowed   (overflowed)
	);

	always #6 clk = ~clk;

	// Predictor state: a copy of the store, its fill level, the overflow mark and the limit.
	entry_t       held[CAPACITY];
	int           held_count = 0;
	bit           held_overflow = 1'b0;
	int           emit_limit = 0;

	pair_item_t   pending_pairs[$];
	result_word_t expected_words[$];
	int           send_gap_pct = 35;
	int           mismatches = 0;
	int           pairs_taken = 0;
	int           runs_flushed = 0;
	int           words_checked = 0;
	int           overflow_words = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("ERROR %0t ns: %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// Takes one accepted pair into the predicted store. On the last pair of a run the store
	// is put in descending timestamp order (stable), the limited words are queued, and the
	// store is emptied.
	function automatic void absorb_pair(input pair_item_t item);
		int           i;
		int           j;
		int           n;
		bit           seen;
		entry_t       key;
		result_word_t word;

		seen = 1'b0;
		for (i = 0; i < held_count; i++)
			if (held[i].offset == item.pair.offset)
				seen = 1'b1;
		// The duplicate test comes first, so a repeated offset never marks an overflow.
		if (!seen) begin
			if (held_count >= CAPACITY) begin
				held_overflow = 1'b1;
			end else begin
				held[held_count] = item.pair;
				held_count++;
			end
		end
		if (!item.eos)
			return;

		for (i = 1; i < held_count; i++) begin
			key = held[i];
			j = i;
			while (j > 0) begin
				if ($signed(held[j-1].ts) >= $signed(key.ts))
					break;
				held[j] = held[j-1];
				j--;
			end
			held[j] = key;
		end

		n = held_count;
		if (emit_limit != 0 && n > emit_limit)
			n = emit_limit;
		for (i = 0; i < n; i++) begin
			word.pair = held[i];
			word.last = (i == n - 1);
			word.ovf  = held_overflow;
			expected_words.push_back(word);
		end
		held_count    = 0;
		held_overflow = 1'b0;
		runs_flushed++;
	endfunction

	// Sender: presents the oldest pending pair and holds it until busy is low at an edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				absorb_pair(pending_pairs.pop_front());
				pairs_taken++;
			end
			if (!start || !busy) begin
				if (pending_pairs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					start         <= 1'b1;
					record_offset <= pending_pairs[0].pair.offset;
					timestamp     <= pending_pairs[0].pair.ts;
					end_of_set    <= pending_pairs[0].eos;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Receiver: every strobed word is taken and compared with the oldest expected word.
	always @(posedge clk) begin
		result_word_t want;
		if (arst_n && result_valid) begin
			if (expected_words.size() == 0) begin
				report_mismatch("result word with none expected", out_offset, 'x);
			end else begin
				want = expected_words.pop_front();
				if (out_offset !== want.pair.offset)
					report_mismatch("out_offset", out_offset, want.pair.offset);
				if (out_timestamp !== want.pair.ts)
					report_mismatch("out_timestamp", out_timestamp, want.pair.ts);
				if (last_result !== want.last)
					report_mismatch("last_result", 64'(last_result), 64'(want.last));
				if (overflowed !== want.ovf)
					report_mismatch("overflowed", 64'(overflowed), 64'(want.ovf));
				words_checked++;
				if (want.ovf)
					overflow_words++;
			end
		end
	end

	task automatic queue_pair(input logic [63:0] off, input logic signed [63:0] ts,
			input logic eos);
		pair_item_t item;
		item.pair.offset = off;
		item.pair.ts     = ts;
		item.eos         = eos;
		pending_pairs.push_back(item);
	endtask

	// Extremes, small values that tie often, and full random patterns.
	function automatic logic signed [63:0] pick_timestamp();
		case ($urandom_range(9))
			0:       return TS_MAX;
			1:       return TS_MIN;
			2, 3, 4: return 64'($urandom_range(4)) - 64'd2;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Runs of one to ten pairs; about a quarter of the offsets repeat one of the same run.
	task automatic queue_random_runs(input int pairs);
		int          left;
		int          len;
		int          i;
		logic [63:0] off;
		logic [63:0] used[$];

		left = pairs;
		while (left > 0) begin
			len = $urandom_range(1, 10);
			if (len > left)
				len = left;
			used.delete();
			for (i = 0; i < len; i++) begin
				if (used.size() != 0 && $urandom_range(99) < 25)
					off = used[$urandom_range(used.size() - 1)];
				else if ($urandom_range(3) == 0)
					off = 64'($urandom_range(15));
				else
					off = {$urandom, $urandom};
				queue_pair(off, pick_timestamp(), i == len - 1);
				used.push_back(off);
			end
			left -= len;
		end
	endtask

	// Fills the store with 64 distinct offsets, then sends repeats and new pairs into the
	// full store; the first extra pair is a repeat and the second a new one, so the run's
	// words must all carry the overflow mark.
	task automatic queue_overflow_run();
		int          extra;
		int          i;
		logic [63:0] off;
		logic [63:0] used[$];

		for (i = 0; i < CAPACITY; i++) begin
			off = {$urandom, $urandom};
			off[5:0] = i[5:0];
			queue_pair(off, pick_timestamp(), 1'b0);
			used.push_back(off);
		end
		extra = $urandom_range(3, 6);
		for (i = 0; i < extra; i++) begin
			if (i == 0 || (i > 1 && $urandom_range(1) == 0))
				off = used[$urandom_range(CAPACITY - 1)];
			else
				off = {$urandom, $urandom};
			queue_pair(off, pick_timestamp(), i == extra - 1);
		end
	endtask

	task automatic write_result_limit(input logic [6:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		emit_limit = value;
		cfg_valid <= 1'b0;
	endtask

	// Holds the sender back until every queued pair is taken and every word has come out.
	task automatic wait_until_drained();
		do @(posedge clk);
		while (pending_pairs.size() != 0 || start || busy || expected_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed runs. The first mixes the extreme offsets and timestamps, a repeated
		// offset and three equal timestamps that must keep their arrival order.
		write_result_limit(7'd0);
		queue_pair(64'd0, TS_MAX, 1'b0);
		queue_pair('1, TS_MIN, 1'b0);
		queue_pair(64'd5, 64'sd0, 1'b0);
		queue_pair(64'd5, 64'sd100, 1'b0);
		queue_pair(64'd7, 64'sd0, 1'b0);
		queue_pair(64'd8, -64'sd1, 1'b0);
		queue_pair(64'd9, 64'sd0, 1'b1);
		// A run of a single pair.
		queue_pair(64'h0000_0001_0000_0003, 64'sd42, 1'b1);
		wait_until_drained();

		// The smallest limit, with a run whose last pair is a repeat.
		write_result_limit(7'd1);
		queue_pair(64'd10, -64'sd5, 1'b0);
		queue_pair(64'd11, 64'sd50, 1'b0);
		queue_pair(64'd12, 64'sd50, 1'b0);
		queue_pair(64'd10, 64'sd99, 1'b1);
		wait_until_drained();

		write_result_limit(7'd3);
		queue_pair(64'd20, 64'sd3, 1'b0);
		queue_pair(64'd21, 64'sd3, 1'b0);
		queue_pair(64'd22, 64'sd7, 1'b0);
		queue_pair(64'd23, 64'sd3, 1'b0);
		queue_pair(64'd24, -64'sd3, 1'b1);
		wait_until_drained();

		// The largest register value lies above any possible count.
		write_result_limit(7'd127);
		queue_pair(64'd30, 64'sd1, 1'b0);
		queue_pair(64'd31, 64'sd2, 1'b0);
		queue_pair(64'd32, 64'sd0, 1'b1);
		wait_until_drained();

		// Random phase with a frequently idle sender, paused half-way until all words are out.
		write_result_limit(7'd64);
		queue_random_runs(18);
		wait_until_drained();
		queue_random_runs(17);
		wait_until_drained();

		// A mostly idle sender: the full store with overflow, then a small random limit.
		send_gap_pct = 85;
		write_result_limit(7'd0);
		queue_overflow_run();
		wait_until_drained();
		write_result_limit(7'($urandom_range(2, 10)));
		queue_random_runs(20);
		wait_until_drained();

		// Back-to-back pairs.
		send_gap_pct = 0;
		write_result_limit(7'($urandom_range(1, 20)));
		queue_random_runs(25);
		wait_until_drained();

		$display("Run covered %0d pairs in %0d sets: %0d result words checked, %0d of them",
			pairs_taken, runs_flushed, words_checked, overflow_words);
		$display("from a set that overflowed the store; %0d mismatches.", mismatches);
		if (mismatches == 0) begin
			$display("PASS dedup_sorted_result_buffer");
		end else begin
			$display("FAIL dedup_sorted_result_buffer");
		end
		$finish;
	end

	// Generous ceiling: the whole run needs well under a tenth of this.
	initial begin
		#4_000_000;
		$display("Timed out with %0d pairs pending and %0d words outstanding.",
			pending_pairs.size(), expected_words.size());
		$display("FAIL dedup_sorted_result_buffer");
		$finish;
	end

endmodule
